// ===== rtl/threshold_ordered_multiset_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the threshold ordered multiset
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_ORDERED_MULTISET_DEFINES_SVH
`define THRESHOLD_ORDERED_MULTISET_DEFINES_SVH

// same-cycle implication
`define TOM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TOM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tom_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tom_pkg
// Types, sizes and helpers shared by the threshold ordered multiset.
// ----------------------------------------------------------------------------
package tom_pkg;

    localparam int CAPACITY   = 1024;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int VAL_W      = 48;
    localparam int OP_W       = 31;
    localparam int FLOOR_W    = 32;
    localparam int DEP_W      = 32;
    localparam int KIND_W     = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = VAL_W + DEP_W;
    localparam int OUT_USER_W = 2;

    localparam int GRP_SIZE   = (CAPACITY < 32) ? CAPACITY : 32;
    localparam int NGRP       = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int LEAF_N     = NGRP * GRP_SIZE;

    typedef logic signed [VAL_W-1:0] val_t;

    localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_RAISE  = 2'd1,
        KIND_LOWER  = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_EVICT,
        CELL_INSERT,
        CELL_RAISE,
        CELL_LOWER,
        CELL_QUERY
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT,
        ST_COUNT,
        ST_APPLY,
        ST_QREAD,
        ST_DONE
    } tom_state_t;

    typedef struct packed {
        cell_op_t           op;
        val_t               operand;
        val_t               floor_v;
        logic [IDX_W-1:0]   rank;
        logic [CNT_W-1:0]   count;
    } cmd_t;

    typedef struct packed {
        logic hit;
        val_t data;
    } leaf_t;

    function automatic val_t sat_add(input val_t a, input val_t b, input logic neg);
        logic [VAL_W:0] s;
        val_t           r;
        begin
            if (neg) begin
                s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
            end else begin
                s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
            end
            if (s[VAL_W] != s[VAL_W-1]) begin
                r = s[VAL_W] ? VAL_MIN : VAL_MAX;
            end else begin
                r = s[VAL_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/tom_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tom_cell
// One slot of the descending sorted chain: holds a value, shifts on insert,
// adjusts on raise and lower, and offers a leaf to the reduction tree.
// ----------------------------------------------------------------------------
module tom_cell (
    input  logic                        aclk,
    input  logic [tom_pkg::IDX_W-1:0]   cell_idx,
    input  tom_pkg::cmd_t               cmd,
    input  tom_pkg::val_t               left_val,
    input  logic                        left_gt,
    input  logic                        left_keep,
    output tom_pkg::val_t               val,
    output logic                        gt,
    output logic                        keep,
    output tom_pkg::leaf_t              leaf
);
    import tom_pkg::*;

    val_t val_reg;
    val_t val_next;
    logic occupied;

    always_comb begin
        occupied = CNT_W'(cell_idx) < cmd.count;
        gt       = occupied && ($signed(val_reg) > $signed(cmd.operand));
        keep     = occupied && ($signed(val_reg) >= $signed(cmd.floor_v));
    end

    always_comb begin
        val_next = val_reg;
        case (cmd.op)
            CELL_INSERT: begin
                if (!gt) begin
                    val_next = left_gt ? cmd.operand : left_val;
                end
            end
            CELL_RAISE: val_next = sat_add(val_reg, cmd.operand, 1'b0);
            CELL_LOWER: val_next = sat_add(val_reg, cmd.operand, 1'b1);
            default:    val_next = val_reg;
        endcase
    end

    always_comb begin
        leaf = '0;
        case (cmd.op)
            CELL_EVICT: begin
                leaf.hit  = !keep && left_keep;
                leaf.data = val_t'(cell_idx);
            end
            CELL_QUERY: begin
                leaf.hit  = (cell_idx == cmd.rank);
                leaf.data = val_reg;
            end
            default: leaf = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ===== rtl/tom_or_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tom_or_tree
// Two-level OR reduction of one-hot leaves; the group level is registered.
// ----------------------------------------------------------------------------
module tom_or_tree (
    input  logic            aclk,
    input  tom_pkg::leaf_t  leaves [tom_pkg::LEAF_N],
    output tom_pkg::leaf_t  result
);
    import tom_pkg::*;

    leaf_t grp_reg  [NGRP];
    leaf_t grp_next [NGRP];

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                if (leaves[g*GRP_SIZE+j].hit) begin
                    grp_next[g].hit  = 1'b1;
                    grp_next[g].data = grp_next[g].data | leaves[g*GRP_SIZE+j].data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NGRP; g++) begin
            grp_reg[g] <= grp_next[g];
        end
    end

    always_comb begin
        result = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (grp_reg[g].hit) begin
                result.hit  = 1'b1;
                result.data = result.data | grp_reg[g].data;
            end
        end
    end

endmodule

// ===== rtl/threshold_ordered_multiset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_ordered_multiset
// Sorted multiset of signed values held largest first in a chain of cells,
// with a floor below which values are evicted and a rank query.
//
//   channel | direction | tdata (low bit up)      | tuser (low bit up)
//   s_      | in        | operand[30:0], pad      | kind[1:0]
//   m_      | out       | answer[47:0], departed  | found, dropped
//   cfg_    | in        | floor_value[31:0]       | -
//
// Insert and raise go evict, count, apply, done; query reads the tree before
// done; lower runs the eviction pass twice. Each eviction pass and each query
// reads the cells through the two-level reduction tree, one register deep.
// A new item is taken while the previous result waits in the output register.
// Reset clears the count, the floor, the departed total and the output valid.
// ----------------------------------------------------------------------------
module threshold_ordered_multiset (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tom_pkg::IN_DATA_W-1:0]       s_tdata,   // operand[30:0], zero pad
    input  logic [tom_pkg::KIND_W-1:0]          s_tuser,   // kind[1:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tom_pkg::OUT_DATA_W-1:0]      m_tdata,   // answer[47:0], departed[79:48]
    output logic [tom_pkg::OUT_USER_W-1:0]      m_tuser,   // found[0], dropped[1]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tom_pkg::FLOOR_W-1:0]         cfg_data
);
    import tom_pkg::*;

    tom_state_t              state_reg, state_next;
    kind_t                   kind_reg;
    logic [OP_W-1:0]         operand_reg;
    logic [FLOOR_W-1:0]      floor_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [DEP_W-1:0]        departed_reg;
    logic                    pass_reg;
    logic                    found_reg;
    logic                    dropped_reg;
    val_t                    answer_reg;
    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic [OUT_USER_W-1:0]   m_tuser_reg;

    cmd_t                    cmd;
    logic                    accept;
    logic                    out_free;
    logic                    out_load;
    val_t                    floor_ext;
    val_t                    operand_ext;
    logic                    ins_ge_floor;
    logic                    has_room;
    logic [CNT_W-1:0]        new_count;
    logic [CNT_W-1:0]        evicted;
    logic [DEP_W:0]          dep_sum;
    logic                    q_found;
    leaf_t                   tree_res;

    val_t                    chain_val  [CAPACITY+1];
    logic                    chain_gt   [CAPACITY+1];
    logic                    chain_keep [CAPACITY+1];
    leaf_t                   leaves     [LEAF_N];

    always_comb begin
        floor_ext    = {{(VAL_W-FLOOR_W){floor_reg[FLOOR_W-1]}}, floor_reg};
        operand_ext  = {{(VAL_W-OP_W){1'b0}}, operand_reg};
        ins_ge_floor = $signed(operand_ext) >= $signed(floor_ext);
        has_room     = count_reg < CNT_W'(CAPACITY);
        new_count    = tree_res.hit ? tree_res.data[CNT_W-1:0] : count_reg;
        evicted      = count_reg - new_count;
        dep_sum      = {1'b0, departed_reg} + (DEP_W+1)'(evicted);
        q_found      = (operand_reg != '0) && (operand_reg <= OP_W'(count_reg));
        out_free     = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT: state_next = ST_COUNT;
            ST_COUNT: state_next = pass_reg ? ST_DONE : ST_APPLY;
            ST_APPLY: begin
                case (kind_reg)
                    KIND_QUERY: state_next = ST_QREAD;
                    KIND_LOWER: state_next = ST_EVICT;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_QREAD: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = (state_reg == ST_IDLE);
        accept      = s_tvalid && s_tready;
        out_load    = (state_reg == ST_DONE) && out_free;
        cmd.operand = operand_ext;
        cmd.floor_v = floor_ext;
        cmd.rank    = IDX_W'(operand_reg - OP_W'(1));
        cmd.count   = count_reg;
        cmd.op      = CELL_HOLD;
        case (state_reg)
            ST_EVICT: cmd.op = CELL_EVICT;
            ST_APPLY: begin
                case (kind_reg)
                    KIND_INSERT: cmd.op = (ins_ge_floor && has_room) ? CELL_INSERT
                                                                     : CELL_HOLD;
                    KIND_RAISE:  cmd.op = CELL_RAISE;
                    KIND_LOWER:  cmd.op = CELL_LOWER;
                    KIND_QUERY:  cmd.op = CELL_QUERY;
                    default:     cmd.op = CELL_HOLD;
                endcase
            end
            default: cmd.op = CELL_HOLD;
        endcase
    end

    assign chain_val[0]  = '0;
    assign chain_gt[0]   = 1'b1;
    assign chain_keep[0] = 1'b1;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        tom_cell u_cell (
            .aclk      (aclk),
            .cell_idx  (IDX_W'(i)),
            .cmd       (cmd),
            .left_val  (chain_val[i]),
            .left_gt   (chain_gt[i]),
            .left_keep (chain_keep[i]),
            .val       (chain_val[i+1]),
            .gt        (chain_gt[i+1]),
            .keep      (chain_keep[i+1]),
            .leaf      (leaves[i])
        );
    end

    for (genvar i = CAPACITY; i < LEAF_N; i++) begin : g_pad
        assign leaves[i] = '0;
    end

    tom_or_tree u_tree (
        .aclk   (aclk),
        .leaves (leaves),
        .result (tree_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            floor_reg    <= '0;
            count_reg    <= '0;
            departed_reg <= '0;
            pass_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                floor_reg <= cfg_data;
            end
            if (accept) begin
                pass_reg <= 1'b0;
            end
            if (state_reg == ST_COUNT) begin
                count_reg    <= new_count;
                departed_reg <= dep_sum[DEP_W] ? {DEP_W{1'b1}} : dep_sum[DEP_W-1:0];
            end
            if (cmd.op == CELL_INSERT) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (state_reg == ST_APPLY && kind_reg == KIND_LOWER) begin
                pass_reg <= 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg    <= kind_t'(s_tuser);
            operand_reg <= s_tdata[OP_W-1:0];
            found_reg   <= 1'b0;
            dropped_reg <= 1'b0;
            answer_reg  <= '0;
        end
        if (state_reg == ST_APPLY && kind_reg == KIND_INSERT) begin
            dropped_reg <= ins_ge_floor && !has_room;
        end
        if (state_reg == ST_QREAD) begin
            found_reg  <= q_found;
            answer_reg <= q_found ? tree_res.data : '0;
        end
        if (out_load) begin
            m_tdata_reg <= {departed_reg, answer_reg};
            m_tuser_reg <= {dropped_reg, found_reg};
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule

// ===== rtl/tom_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tom_checker
// Port-level checks on the threshold ordered multiset, bound to the top.
// ----------------------------------------------------------------------------
`include "threshold_ordered_multiset_defines.svh"

module tom_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [tom_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic [tom_pkg::OUT_USER_W-1:0]  m_tuser
);
    import tom_pkg::*;

    `TOM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")
    `TOM_ASSERT_IMP(a_answer_zero, m_tvalid && !m_tuser[0], m_tdata[VAL_W-1:0] == '0, "answer nonzero without found")
    `TOM_ASSERT_IMP(a_flags_excl, m_tvalid, !(m_tuser[0] && m_tuser[1]), "found and dropped both set")
    `TOM_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "item taken while another is in work")

endmodule

bind threshold_ordered_multiset tom_checker u_tom_checker (.*);
